// ===== rtl/rsip_pkg.sv =====
`default_nettype none

package rsip_pkg;

  // Kind of piece carried by a result beat.
  typedef enum logic [1:0] {
    KIND_TOP    = 2'd0,
    KIND_BOTTOM = 2'd1,
    KIND_LEFT   = 2'd2,
    KIND_RIGHT  = 2'd3
  } piece_kind_t;

  // Number of piece lanes held in the result buffer.
  localparam int unsigned NUM_LANES = 4;

  // One piece as it leaves on the result ports.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] w;
    logic [30:0] h;
    logic        none;
  } piece_t;

endpackage

`default_nettype wire

// ===== rtl/rect_subtract_into_pieces.sv =====
`default_nettype none

// Subtracts a hole rectangle from an outer rectangle (signed Q16.16) and
// returns the remaining area as up to four pieces: top band, bottom band,
// left side and right side, in that order, or one beat with no_pieces set.
// A command is taken when start is high and busy is low. It passes four
// arithmetic register stages (standardize, edges, margins, side extent),
// a four-lane result buffer and the result registers in that order; the
// buffer loads only when it has at most one beat left to send. Results
// leave one per cycle with done high for that single cycle, and the
// receiver must take every beat. A command yields between one and four
// results (one when nothing is left), sent back to back, and the buffer
// takes the next command's pieces while the last beat of the one before
// leaves; busy rises when all four stages hold a command and the result
// buffer still has more than one beat to send. All edge sums and all
// results are saturated to the signed COORD_BITS range.
module rect_subtract_into_pieces #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [31:0]  outer_x,
  input  wire logic signed [31:0]  outer_y,
  input  wire logic signed [31:0]  outer_w,
  input  wire logic signed [31:0]  outer_h,
  input  wire logic signed [31:0]  hole_x,
  input  wire logic signed [31:0]  hole_y,
  input  wire logic signed [31:0]  hole_w,
  input  wire logic signed [31:0]  hole_h,
  output logic                     done,
  output logic signed [31:0]       piece_x,
  output logic signed [31:0]       piece_y,
  output logic [30:0]              piece_w,
  output logic [30:0]              piece_h,
  output logic [1:0]               piece_kind,
  output logic                     no_pieces,
  output logic                     last_piece
);

  // Internal width: the larger of the saturation range and the input width,
  // with headroom for a difference of differences.
  localparam int MAXW = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int IW   = MAXW + 3;

  localparam logic signed [IW-1:0] SAT_HI = (IW'(1) << (COORD_BITS - 1)) - IW'(1);
  localparam logic signed [IW-1:0] SAT_LO = -SAT_HI - IW'(1);
  localparam logic signed [IW-1:0] ZERO   = '0;

  function automatic logic signed [IW-1:0] sat(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r;
  endfunction

  function automatic logic signed [IW-1:0] sx(input logic [31:0] v);
    return {{(IW-32){v[31]}}, v};
  endfunction

  // Origin after standardizing: moves by the size when the size is negative.
  function automatic logic signed [IW-1:0] std_p(input logic signed [IW-1:0] p,
                                                 input logic signed [IW-1:0] s);
    logic signed [IW-1:0] r;
    r = p;
    if (s < ZERO) begin
      r = sat(p + s);
    end
    return r;
  endfunction

  function automatic logic signed [IW-1:0] std_s(input logic signed [IW-1:0] s);
    logic signed [IW-1:0] r;
    r = s;
    if (s < ZERO) begin
      r = sat(-s);
    end
    return r;
  endfunction

  function automatic logic [31:0] to_coord(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] t;
    t = sat(v);
    return t[31:0];
  endfunction

  function automatic logic [30:0] to_size(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] t;
    t = sat(v);
    if (v < ZERO) begin
      t = ZERO;
    end
    return t[30:0];
  endfunction

  // Pipeline valid bits and stage enables.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic buf_free;
  logic accept;

  logic [rsip_pkg::NUM_LANES-1:0] mask;

  assign buf_free = ((mask & (mask - 4'd1)) == 4'd0);
  assign en4      = !v4 || buf_free;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign busy     = !en1;
  assign accept   = start && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  // Stage 1: standardize both rectangles on both axes.
  logic signed [IW-1:0] ox1, oy1, ow1, oh1, hx1, hy1, hw1, hh1;

  always_ff @(posedge clk) begin
    if (en1) begin
      ox1 <= std_p(sx(outer_x), sx(outer_w));
      ow1 <= std_s(sx(outer_w));
      oy1 <= std_p(sx(outer_y), sx(outer_h));
      oh1 <= std_s(sx(outer_h));
      hx1 <= std_p(sx(hole_x), sx(hole_w));
      hw1 <= std_s(sx(hole_w));
      hy1 <= std_p(sx(hole_y), sx(hole_h));
      hh1 <= std_s(sx(hole_h));
    end
  end

  // Stage 2: far edges of both rectangles.
  logic signed [IW-1:0] ox2, oy2, ow2, oh2, hx2, hy2, hw2, hh2;
  logic signed [IW-1:0] oxe2, oye2, hxe2, hye2;

  always_ff @(posedge clk) begin
    if (en2) begin
      ox2  <= ox1;
      oy2  <= oy1;
      ow2  <= ow1;
      oh2  <= oh1;
      hx2  <= hx1;
      hy2  <= hy1;
      hw2  <= hw1;
      hh2  <= hh1;
      oxe2 <= sat(ox1 + ow1);
      oye2 <= sat(oy1 + oh1);
      hxe2 <= sat(hx1 + hw1);
      hye2 <= sat(hy1 + hh1);
    end
  end

  // Stage 3: overlap test and the four margins.
  logic signed [IW-1:0] ox3, oy3, ow3, oh3, hxe3, hye3;
  logic signed [IW-1:0] top3, bottom3, left3, right3;
  logic                 ov3;

  always_ff @(posedge clk) begin
    if (en3) begin
      ox3     <= ox2;
      oy3     <= oy2;
      ow3     <= ow2;
      oh3     <= oh2;
      hxe3    <= hxe2;
      hye3    <= hye2;
      top3    <= hy2 - oy2;
      bottom3 <= oye2 - hye2;
      left3   <= hx2 - ox2;
      right3  <= oxe2 - hxe2;
      ov3     <= (ow2 > ZERO) && (oh2 > ZERO) && (hw2 > ZERO) && (hh2 > ZERO) &&
                 (ox2 < hxe2) && (hx2 < oxe2) && (oy2 < hye2) && (hy2 < oye2);
    end
  end

  // Stage 4: height left between the bands, its upper edge and the piece mask.
  logic signed [IW-1:0] ox4, oy4, ow4, hxe4, hye4;
  logic signed [IW-1:0] top4, bottom4, left4, right4, extent4, ytop4;
  logic [rsip_pkg::NUM_LANES-1:0] mask4;

  logic signed [IW-1:0] top_used, bottom_used, extent_c;
  logic                 top_pos, bottom_pos;

  always_comb begin
    top_pos     = top3 > ZERO;
    bottom_pos  = bottom3 > ZERO;
    top_used    = top_pos ? top3 : ZERO;
    bottom_used = bottom_pos ? bottom3 : ZERO;
    extent_c    = oh3 - top_used - bottom_used;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ox4      <= ox3;
      oy4      <= oy3;
      ow4      <= ow3;
      hxe4     <= hxe3;
      hye4     <= hye3;
      top4     <= top3;
      bottom4  <= bottom3;
      left4    <= left3;
      right4   <= right3;
      extent4  <= extent_c;
      ytop4    <= sat(oy3 + top_used);
      mask4[0] <= ov3 && top_pos;
      mask4[1] <= ov3 && bottom_pos;
      mask4[2] <= ov3 && (extent_c > ZERO) && (left3 > ZERO);
      mask4[3] <= ov3 && (extent_c > ZERO) && (right3 > ZERO);
    end
  end

  // Result buffer: one lane per piece kind, emptied one beat per cycle.
  rsip_pkg::piece_t lane [rsip_pkg::NUM_LANES];
  rsip_pkg::piece_t lane_load [rsip_pkg::NUM_LANES];
  logic [rsip_pkg::NUM_LANES-1:0] load_mask;
  logic                           buf_load;

  assign buf_load = v4 && buf_free;

  always_comb begin
    lane_load[0] = '{x: to_coord(ox4), y: to_coord(oy4), w: to_size(ow4),
                     h: to_size(top4), none: 1'b0};
    lane_load[1] = '{x: to_coord(ox4), y: to_coord(hye4), w: to_size(ow4),
                     h: to_size(bottom4), none: 1'b0};
    lane_load[2] = '{x: to_coord(ox4), y: to_coord(ytop4), w: to_size(left4),
                     h: to_size(extent4), none: 1'b0};
    lane_load[3] = '{x: to_coord(hxe4), y: to_coord(ytop4), w: to_size(right4),
                     h: to_size(extent4), none: 1'b0};
    load_mask    = mask4;
    // Nothing left of the outer rectangle: a single empty beat in the top lane.
    if (mask4 == 4'd0) begin
      lane_load[0] = '{x: '0, y: '0, w: '0, h: '0, none: 1'b1};
      load_mask    = 4'b0001;
    end
  end

  // Pick the lowest pending lane for the next beat.
  rsip_pkg::piece_kind_t          sel;
  logic [rsip_pkg::NUM_LANES-1:0] sel_bit;
  logic [rsip_pkg::NUM_LANES-1:0] mask_left;

  always_comb begin
    case (1'b1)
      mask[0]: begin
        sel     = rsip_pkg::KIND_TOP;
        sel_bit = 4'b0001;
      end
      mask[1]: begin
        sel     = rsip_pkg::KIND_BOTTOM;
        sel_bit = 4'b0010;
      end
      mask[2]: begin
        sel     = rsip_pkg::KIND_LEFT;
        sel_bit = 4'b0100;
      end
      mask[3]: begin
        sel     = rsip_pkg::KIND_RIGHT;
        sel_bit = 4'b1000;
      end
      default: begin
        sel     = rsip_pkg::KIND_TOP;
        sel_bit = 4'b0000;
      end
    endcase
    mask_left = mask & ~sel_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (buf_load) begin
      mask <= load_mask;
    end else begin
      mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      for (int i = 0; i < rsip_pkg::NUM_LANES; i++) begin
        lane[i] <= lane_load[i];
      end
    end
  end

  // Result registers: each beat is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= |mask;
    end
  end

  always_ff @(posedge clk) begin
    piece_x    <= lane[sel].x;
    piece_y    <= lane[sel].y;
    piece_w    <= lane[sel].w;
    piece_h    <= lane[sel].h;
    piece_kind <= sel;
    no_pieces  <= lane[sel].none;
    last_piece <= (mask_left == 4'd0);
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;

  localparam int U           = 65536;
  localparam int MIN_C       = 32'sh8000_0000;
  localparam int MAX_C       = 32'sh7fff_ffff;
  localparam int RAND_ITEMS  = 138;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 40;
  localparam int LATENCY     = 6;

  // One command as it is put on the input ports.
  typedef struct {
    logic signed [31:0] outer_x;
    logic signed [31:0] outer_y;
    logic signed [31:0] outer_w;
    logic signed [31:0] outer_h;
    logic signed [31:0] hole_x;
    logic signed [31:0] hole_y;
    logic signed [31:0] hole_w;
    logic signed [31:0] hole_h;
  } rect_cmd_t;

  // One expected result beat.
  typedef struct {
    logic signed [31:0]    x;
    logic signed [31:0]    y;
    logic [30:0]           w;
    logic [30:0]           h;
    rsip_pkg::piece_kind_t kind;
    logic                  none;
    logic                  last;
  } piece_beat_t;

  // A directed row; empty marks rows whose single empty beat is typed in.
  typedef struct {
    rect_cmd_t cmd;
    bit        empty;
  } dir_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [31:0] outer_x;
  logic signed [31:0] outer_y;
  logic signed [31:0] outer_w;
  logic signed [31:0] outer_h;
  logic signed [31:0] hole_x;
  logic signed [31:0] hole_y;
  logic signed [31:0] hole_w;
  logic signed [31:0] hole_h;
  logic done;
  logic signed [31:0] piece_x;
  logic signed [31:0] piece_y;
  logic [30:0] piece_w;
  logic [30:0] piece_h;
  logic [1:0] piece_kind;
  logic no_pieces;
  logic last_piece;

  piece_beat_t pending_pieces[$];
  dir_row_t    dir_rows[$];
  int mismatches  = 0;
  int cycle_count = 0;
  int cmds_sent   = 0;
  int beats_seen  = 0;
  int empty_seen  = 0;
  int kind_seen [4];

  rect_subtract_into_pieces #(
    .COORD_BITS(32)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .outer_x    (outer_x),
    .outer_y    (outer_y),
    .outer_w    (outer_w),
    .outer_h    (outer_h),
    .hole_x     (hole_x),
    .hole_y     (hole_y),
    .hole_w     (hole_w),
    .hole_h     (hole_h),
    .done       (done),
    .piece_x    (piece_x),
    .piece_y    (piece_y),
    .piece_w    (piece_w),
    .piece_h    (piece_h),
    .piece_kind (piece_kind),
    .no_pieces  (no_pieces),
    .last_piece (last_piece)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Saturates a wide value to the signed 32-bit coordinate range.
  function automatic longint clamp32(input longint v);
    if (v > longint'(MAX_C)) return longint'(MAX_C);
    if (v < longint'(MIN_C)) return longint'(MIN_C);
    return v;
  endfunction

  // Flips a negative size onto the positive side and moves the origin.
  function automatic void norm_axis(input longint p, input longint s,
                                    output longint po, output longint so);
    po = p;
    so = s;
    if (s < 0) begin
      po = clamp32(p + s);
      so = clamp32(-s);
    end
  endfunction

  // Builds one result beat, saturating the coordinates and sizes.
  function automatic piece_beat_t make_piece(input longint x, input longint y,
                                             input longint w, input longint h,
                                             input rsip_pkg::piece_kind_t k,
                                             input logic none);
    piece_beat_t b;
    longint t;
    t = clamp32(x);
    b.x = t[31:0];
    t = clamp32(y);
    b.y = t[31:0];
    t = (w < 0) ? 0 : clamp32(w);
    b.w = t[30:0];
    t = (h < 0) ? 0 : clamp32(h);
    b.h = t[30:0];
    b.kind = k;
    b.none = none;
    b.last = 1'b0;
    return b;
  endfunction

  // Works out the pieces left of the outer rectangle and queues them.
  function automatic void predict_pieces(input rect_cmd_t c);
    longint ox, oy, ow, oh, hx, hy, hw, hh;
    longint oxe, oye, hxe, hye;
    longint top_m, bot_m, lft_m, rgt_m, extent, ytop;
    piece_beat_t beats [4];
    int n;
    n = 0;
    norm_axis(longint'(c.outer_x), longint'(c.outer_w), ox, ow);
    norm_axis(longint'(c.outer_y), longint'(c.outer_h), oy, oh);
    norm_axis(longint'(c.hole_x), longint'(c.hole_w), hx, hw);
    norm_axis(longint'(c.hole_y), longint'(c.hole_h), hy, hh);
    oxe = clamp32(ox + ow);
    oye = clamp32(oy + oh);
    hxe = clamp32(hx + hw);
    hye = clamp32(hy + hh);
    if (ow > 0 && oh > 0 && hw > 0 && hh > 0 &&
        ox < hxe && hx < oxe && oy < hye && hy < oye) begin
      top_m  = hy - oy;
      bot_m  = oye - hye;
      lft_m  = hx - ox;
      rgt_m  = oxe - hxe;
      extent = oh;
      if (top_m > 0) begin
        beats[n] = make_piece(ox, oy, ow, top_m, rsip_pkg::KIND_TOP, 1'b0);
        n++;
        extent -= top_m;
      end else begin
        top_m = 0;
      end
      if (bot_m > 0) begin
        beats[n] = make_piece(ox, oye - bot_m, ow, bot_m, rsip_pkg::KIND_BOTTOM, 1'b0);
        n++;
        extent -= bot_m;
      end
      // Side pieces only exist where some height is left between the bands.
      if (extent > 0) begin
        ytop = clamp32(oy + top_m);
        if (lft_m > 0) begin
          beats[n] = make_piece(ox, ytop, lft_m, extent, rsip_pkg::KIND_LEFT, 1'b0);
          n++;
        end
        if (rgt_m > 0) begin
          beats[n] = make_piece(oxe - rgt_m, ytop, rgt_m, extent,
                                rsip_pkg::KIND_RIGHT, 1'b0);
          n++;
        end
      end
    end
    if (n == 0) begin
      beats[0] = make_piece(0, 0, 0, 0, rsip_pkg::KIND_TOP, 1'b1);
      n = 1;
    end
    beats[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_pieces.push_back(beats[i]);
  endfunction

  // Prints one mismatch line, up to a cap, and counts every one.
  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic add_row(input int ox, input int oy, input int ow, input int oh,
                         input int hx, input int hy, input int hw, input int hh,
                         input bit empty);
    dir_row_t r;
    r.cmd.outer_x = ox;
    r.cmd.outer_y = oy;
    r.cmd.outer_w = ow;
    r.cmd.outer_h = oh;
    r.cmd.hole_x  = hx;
    r.cmd.hole_y  = hy;
    r.cmd.hole_w  = hw;
    r.cmd.hole_h  = hh;
    r.empty       = empty;
    dir_rows.push_back(r);
  endtask

  // Puts one command on the ports after a gap and waits until it is taken.
  // The empty flag queues the typed-in empty beat instead of a prediction.
  task automatic send_cmd(input rect_cmd_t c, input int gap, input bit empty);
    piece_beat_t b;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    outer_x <= c.outer_x;
    outer_y <= c.outer_y;
    outer_w <= c.outer_w;
    outer_h <= c.outer_h;
    hole_x  <= c.hole_x;
    hole_y  <= c.hole_y;
    hole_w  <= c.hole_w;
    hole_h  <= c.hole_h;
    do @(posedge clk); while (busy !== 1'b0);
    cmds_sent++;
    if (empty) begin
      b = make_piece(0, 0, 0, 0, rsip_pkg::KIND_TOP, 1'b1);
      b.last = 1'b1;
      pending_pieces.push_back(b);
    end else begin
      predict_pieces(c);
    end
  endtask

  // Compares every result beat with the oldest expected one.
  always @(posedge clk) begin : check_results
    piece_beat_t want;
    if (!rst && done !== 1'b0) begin
      beats_seen++;
      if (no_pieces === 1'b1) empty_seen++;
      else if (!$isunknown(piece_kind)) kind_seen[piece_kind]++;
      if (pending_pieces.size() == 0) begin
        log_mismatch("result beat with nothing pending");
      end else begin
        want = pending_pieces.pop_front();
        if (piece_x !== want.x || piece_y !== want.y || piece_w !== want.w ||
            piece_h !== want.h || piece_kind !== want.kind ||
            no_pieces !== want.none || last_piece !== want.last) begin
          log_mismatch($sformatf(
            "got x=%h y=%h w=%h h=%h k=%0d n=%b l=%b exp x=%h y=%h w=%h h=%h k=%0d n=%b l=%b",
            piece_x, piece_y, piece_w, piece_h, piece_kind, no_pieces, last_piece,
            want.x, want.y, want.w, want.h, want.kind, want.none, want.last));
        end
      end
    end
  end

  // Ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still pending",
               cycle_count, pending_pieces.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus: directed table, then random bursts, then drain and verdict.
  initial begin : stimulus
    rect_cmd_t c;
    int v [8];
    int mode, sc, org, sz, horg, hz, base;
    int burst_left, gap;
    for (int k = 0; k < 4; k++) kind_seen[k] = 0;
    rst     = 1'b1;
    start   = 1'b0;
    outer_x = '0;
    outer_y = '0;
    outer_w = '0;
    outer_h = '0;
    hole_x  = '0;
    hole_y  = '0;
    hole_w  = '0;
    hole_h  = '0;

    // Hole in the middle, then the cases that give no piece at all.
    add_row(0, 0, 10*U, 10*U, 2*U, 2*U, 4*U, 4*U, 1'b0);
    add_row(0, 0, U, U, 5*U, 5*U, U, U, 1'b1);
    add_row(0, 0, 0, 10*U, 0, 0, 5*U, 5*U, 1'b1);
    add_row(0, 0, 10*U, 10*U, 2*U, 2*U, 4*U, 0, 1'b1);
    add_row(U, U, 2*U, 2*U, 0, 0, 10*U, 10*U, 1'b1);
    add_row(0, 0, 4*U, 4*U, 4*U, 0, 4*U, 4*U, 1'b1);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    // Negative sizes on both rectangles.
    add_row(10*U, 10*U, -10*U, -10*U, 8*U, 8*U, -4*U, -4*U, 1'b0);
    // Each kind of piece on its own, and both bands without sides.
    add_row(0, 0, 4*U, 4*U, 0, 2*U, 4*U, 4*U, 1'b0);
    add_row(0, 0, 4*U, 4*U, 0, -2*U, 4*U, 4*U, 1'b0);
    add_row(0, 0, 4*U, 4*U, 2*U, -U, 4*U, 6*U, 1'b0);
    add_row(0, 0, 4*U, 4*U, -2*U, -U, 4*U, 6*U, 1'b0);
    add_row(0, 0, 4*U, 4*U, -U, U, 6*U, 2*U, 1'b0);
    // Extremes: full range, flipped most negative size, saturated edges.
    add_row(MIN_C, MIN_C, MAX_C, MAX_C, -4*U, -4*U, U, U, 1'b0);
    add_row(0, 0, MIN_C, MIN_C, -5*U, -5*U, U, U, 1'b0);
    add_row(MAX_C, MAX_C, MAX_C, MAX_C, 0, 0, MAX_C, MAX_C, 1'b1);
    add_row(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 1'b0);
    add_row(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, 1, MAX_C, 1'b0);
    add_row(32'sh7fff_0000, 32'sh7fff_0000, MAX_C, MAX_C,
            32'sh7fff_4000, 32'sh7fff_4000, U/4, U/4, 1'b0);
    add_row(MIN_C, MAX_C, MAX_C, MIN_C, 0, -2*U, MIN_C, 3*U, 1'b0);
    // Fractional coordinates and single-step sizes.
    add_row(32'sh0000_8000, -32'sh0000_4000, 32'sh0003_1234, 32'sh0002_abcd,
            32'sh0001_0001, 32'sh0000_c000, 32'sh0000_7fff, U, 1'b0);
    add_row(-1, -1, 2, 2, 0, 0, 1, 1, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, (i % 5 == 3) ? int'($urandom_range(1, 4)) : 0,
               dir_rows[i].empty);
    end

    // Random part, sent in bursts with gaps in between.
    burst_left = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 9));
      end
      burst_left--;
      mode = $urandom_range(0, 99);
      if (mode < 65) begin
        // Well-formed pair: the hole lands on or near the outer rectangle.
        sc = 1 << $urandom_range(2, 24);
        for (int a = 0; a < 2; a++) begin
          org  = int'($urandom_range(0, 2*sc)) - sc;
          sz   = $urandom_range(1, sc);
          hz   = ($urandom_range(0, 7) == 0) ? 2*sz : int'($urandom_range(1, sz));
          horg = org - sz/4 + int'($urandom_range(0, sz));
          v[a]   = org;
          v[2+a] = sz;
          v[4+a] = horg;
          v[6+a] = hz;
          if ($urandom_range(0, 1)) begin
            v[a]   = org + sz;
            v[2+a] = -sz;
          end
          if ($urandom_range(0, 1)) begin
            v[4+a] = horg + hz;
            v[6+a] = -hz;
          end
        end
        // Now and then move the pair far out to exercise the high bits.
        if ($urandom_range(0, 9) == 0) begin
          base = $urandom_range(0, 1) ? 32'sh7c00_0000 : -32'sh7c00_0000;
          v[0] += base;
          v[1] += base;
          v[4] += base;
          v[5] += base;
        end
      end else if (mode < 82) begin
        // Mix of extreme values per field.
        for (int a = 0; a < 8; a++) begin
          case ($urandom_range(0, 5))
            0: v[a] = MIN_C;
            1: v[a] = MAX_C;
            2: v[a] = 0;
            3: v[a] = -1;
            4: v[a] = U;
            default: v[a] = $urandom;
          endcase
        end
      end else begin
        for (int a = 0; a < 8; a++) v[a] = $urandom;
      end
      c.outer_x = v[0];
      c.outer_y = v[1];
      c.outer_w = v[2];
      c.outer_h = v[3];
      c.hole_x  = v[4];
      c.hole_y  = v[5];
      c.hole_w  = v[6];
      c.hole_h  = v[7];
      send_cmd(c, gap, 1'b0);
    end
    @(negedge clk);
    start <= 1'b0;

    // Wait for every expected beat, then a few cycles for strays.
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (2*LATENCY) @(posedge clk);

    if (pending_pieces.size() != 0)
      log_mismatch($sformatf("%0d expected beats never arrived", pending_pieces.size()));
    $display("Sent %0d commands, received %0d beats in %0d cycles.",
             cmds_sent, beats_seen, cycle_count);
    $display("Beats by kind: top %0d, bottom %0d, left %0d, right %0d, empty %0d; %0d mismatches.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
